// File: rtl/bbrt_pkg.sv
package bbrt_pkg;

  localparam int BLOCK_W  = 31;
  localparam int OFFSET_W = 10;
  localparam int LENGTH_W = 16;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // First alternate block handed out.
  localparam int ALT_FIRST = 7;

  localparam logic [BLOCK_W-1:0]  LAST_BLOCK_RESET   = '0;
  localparam logic [OFFSET_W-1:0] BLOCK_OFFSET_RESET = 10'd134;

  typedef enum logic [0:0] {
    OP_TRANSLATE = 1'b0,
    OP_REMAP     = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ADDR = 2'd1,
    ST_NO_SPACE = 2'd2
  } status_t;

  // Register select from paddr[2].
  typedef enum logic [0:0] {
    REG_LAST_BLOCK   = 1'b0,
    REG_BLOCK_OFFSET = 1'b1
  } reg_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_NEXT,
    S_SHIFT
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [BLOCK_W-1:0]  block;
    logic [LENGTH_W-1:0] length;
  } req_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] mapped_block;
    logic               all_natural;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]  last_block;
    logic [OFFSET_W-1:0] block_offset;
  } cfg_t;

endpackage

// File: rtl/bad_block_remap_table_unit.sv
// Channel  Ports                                           Transfer when
// request  start, busy, req (op, block, length)            start && !busy
// result   done, rsp (mapped_block, all_natural, status)   done, one cycle, no stall
// config   psel penable pwrite pready paddr pwdata prdata  psel && penable && pwrite && pready
//
// S_CHECK tests range and space, then the search reads the table RAM once a cycle,
// at most log2(min(count, TABLE_ENTRIES/2)) + 1 reads; a translate miss above a slot
// adds one read. A remap miss goes on to the insert, which moves entries up one slot
// at a time, one RAM read and write a cycle. rst is synchronous; the table is empty
// by count, with no clearing pass. done lasts one cycle and cannot be stalled; busy
// drops with it, so the next transfer may overlap.
module bad_block_remap_table_unit #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  bbrt_pkg::req_t              req,
  output logic                        done,
  output bbrt_pkg::rsp_t              rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbrt_pkg::ADDR_W-1:0] paddr,
  input  logic [bbrt_pkg::DATA_W-1:0] pwdata,
  output logic [bbrt_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  import bbrt_pkg::*;

  localparam int AW         = $clog2(TABLE_ENTRIES);
  localparam int ALT_LIMIT  = TABLE_ENTRIES - 1;
  localparam int SEARCH_CAP = TABLE_ENTRIES / 2;
  localparam int ALT_W      = $clog2(TABLE_ENTRIES + ALT_FIRST);
  localparam int WORD_W     = ALT_W + BLOCK_W;

  cfg_t   cfg;
  state_t state, state_next;

  op_t                 op_r, op_next;
  logic [BLOCK_W:0]    ob, ob_next;
  logic [BLOCK_W:0]    ob_end, ob_end_next;
  logic [LENGTH_W-1:0] len_r, len_next;
  logic [AW-1:0]       p, p_next;
  logic [AW-1:0]       step, step_next;
  logic [AW-1:0]       count, count_next;
  logic [AW-1:0]       used, used_next;
  logic [AW-1:0]       y, y_next;
  logic                done_next;
  rsp_t                rsp_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [BLOCK_W-1:0] rd_blk;
  logic [ALT_W-1:0]   rd_alt;
  logic [ALT_W-1:0]   alt_new;
  logic [AW-1:0]      cap;
  logic [AW-1:0]      step_init;
  logic [AW-1:0]      step_half;
  logic               p_valid;
  logic               rd_eq;
  logic               rd_gt;
  logic               in_range;
  logic               full;
  logic               natural_here;
  logic               shift_move;

  bbrt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Each word holds one slot: alternate in the upper bits, bad block below.
  bbrt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE);

  assign rd_blk       = ram_rdata[BLOCK_W-1:0];
  assign rd_alt       = ram_rdata[WORD_W-1:BLOCK_W];
  assign alt_new      = ALT_W'(used) + ALT_W'(ALT_FIRST);
  assign step_half    = step >> 1;
  assign p_valid      = (p != '0) && (p <= count);
  assign rd_eq        = p_valid && (rd_blk == ob[BLOCK_W-1:0]);
  assign rd_gt        = p_valid && (ob[BLOCK_W-1:0] > rd_blk);
  assign in_range     = (ob <= {1'b0, cfg.last_block});
  assign full         = (used >= AW'(ALT_LIMIT));
  assign natural_here = !p_valid || ({1'b0, rd_blk} >= ob_end);
  assign shift_move   = (y >= AW'(2)) && (rd_blk >= ob[BLOCK_W-1:0]);

  // First search step: highest power of two within min(count, half the table).
  always_comb begin
    cap       = (count > AW'(SEARCH_CAP)) ? AW'(SEARCH_CAP) : count;
    step_init = '0;
    for (int i = 0; i < AW; i++) begin
      if (cap[i]) begin
        step_init = AW'(1) << i;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (!in_range) begin
          state_next = S_IDLE;
        end else if (op_r == OP_REMAP && full) begin
          state_next = S_IDLE;
        end else if (count == '0) begin
          state_next = (op_r == OP_TRANSLATE) ? S_IDLE : S_SHIFT;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        priority if (rd_eq) begin
          state_next = S_IDLE;
        end else if (step_half != '0) begin
          state_next = S_SEARCH;
        end else if (op_r == OP_TRANSLATE) begin
          state_next = (rd_gt && p < AW'(ALT_LIMIT)) ? S_NEXT : S_IDLE;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_NEXT: begin
        state_next = S_IDLE;
      end
      S_SHIFT: begin
        state_next = shift_move ? S_SHIFT : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op_next     = op_r;
    ob_next     = ob;
    ob_end_next = ob_end;
    len_next    = len_r;
    p_next      = p;
    step_next   = step;
    count_next  = count;
    used_next   = used;
    y_next      = y;
    done_next   = 1'b0;
    rsp_next    = '{mapped_block: '0, all_natural: 1'b0, status: ST_OK};
    ram_we      = 1'b0;
    ram_waddr   = y;
    ram_wdata   = ram_rdata;
    ram_raddr   = p;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next  = req.op;
          ob_next  = {1'b0, req.block} + (BLOCK_W + 1)'(cfg.block_offset);
          len_next = req.length;
        end
      end
      S_CHECK: begin
        ob_end_next = ob + (BLOCK_W + 1)'(len_r);
        step_next   = step_init;
        p_next      = step_init;
        ram_raddr   = step_init;
        y_next      = count + AW'(1);
        priority if (!in_range) begin
          done_next       = 1'b1;
          rsp_next.status = ST_BAD_ADDR;
        end else if (op_r == OP_REMAP && full) begin
          done_next       = 1'b1;
          rsp_next.status = ST_NO_SPACE;
        end else if (count == '0 && op_r == OP_TRANSLATE) begin
          done_next             = 1'b1;
          rsp_next.mapped_block = ob[BLOCK_W-1:0];
          rsp_next.all_natural  = 1'b1;
        end else begin
          // Remap into an empty table goes straight to the insert.
        end
      end
      S_SEARCH: begin
        step_next = step_half;
        p_next    = rd_gt ? p + step_half : p - step_half;
        ram_raddr = p_next;
        priority if (rd_eq) begin
          done_next = 1'b1;
          if (op_r == OP_TRANSLATE) begin
            rsp_next.mapped_block = BLOCK_W'(rd_alt);
          end else begin
            ram_we                = 1'b1;
            ram_waddr             = p;
            ram_wdata             = {alt_new, ob[BLOCK_W-1:0]};
            used_next             = used + AW'(1);
            rsp_next.mapped_block = BLOCK_W'(alt_new);
          end
        end else if (step_half != '0) begin
          // advance to the next probe
        end else if (op_r == OP_TRANSLATE) begin
          if (rd_gt) begin
            if (p >= AW'(ALT_LIMIT)) begin
              done_next             = 1'b1;
              rsp_next.mapped_block = ob[BLOCK_W-1:0];
              rsp_next.all_natural  = 1'b1;
            end else begin
              p_next    = p + AW'(1);
              ram_raddr = p + AW'(1);
            end
          end else begin
            done_next             = 1'b1;
            rsp_next.mapped_block = ob[BLOCK_W-1:0];
            rsp_next.all_natural  = natural_here;
          end
        end else begin
          // Start the insert from the top slot.
          ram_raddr = count;
        end
      end
      S_NEXT: begin
        done_next             = 1'b1;
        rsp_next.mapped_block = ob[BLOCK_W-1:0];
        rsp_next.all_natural  = natural_here;
      end
      S_SHIFT: begin
        ram_raddr = y - AW'(2);
        ram_we    = 1'b1;
        ram_waddr = y;
        if (shift_move) begin
          ram_wdata = ram_rdata;
          y_next    = y - AW'(1);
        end else begin
          ram_wdata             = {alt_new, ob[BLOCK_W-1:0]};
          count_next            = count + AW'(1);
          used_next             = used + AW'(1);
          done_next             = 1'b1;
          rsp_next.mapped_block = BLOCK_W'(alt_new);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      used  <= '0;
      p     <= '0;
      step  <= '0;
      y     <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      used  <= used_next;
      p     <= p_next;
      step  <= step_next;
      y     <= y_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_next;
    ob     <= ob_next;
    ob_end <= ob_end_next;
    len_r  <= len_next;
    rsp    <= rsp_next;
  end

`ifndef SYNTHESIS
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE)
    else $error("result without a request in progress");

  a_count_within_used: assert property (@(posedge clk) disable iff (rst)
    count <= used)
    else $error("table count exceeds alternates handed out");

  a_step_onehot: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> $onehot(step))
    else $error("search step is not a single power of two");
`endif

endmodule

// File: rtl/bbrt_ram.sv
module bbrt_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bbrt_cfg.sv
module bbrt_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbrt_pkg::ADDR_W-1:0]   paddr,
  input  logic [bbrt_pkg::DATA_W-1:0]   pwdata,
  output logic [bbrt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output bbrt_pkg::cfg_t                cfg
);

  import bbrt_pkg::*;

  reg_sel_t sel;
  logic     wr;

  assign pready = 1'b1;
  assign sel    = reg_sel_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.last_block   <= LAST_BLOCK_RESET;
      cfg.block_offset <= BLOCK_OFFSET_RESET;
    end else if (wr) begin
      unique case (sel)
        REG_LAST_BLOCK:   cfg.last_block   <= pwdata[BLOCK_W-1:0];
        REG_BLOCK_OFFSET: cfg.block_offset <= pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_LAST_BLOCK:   prdata = DATA_W'(cfg.last_block);
      REG_BLOCK_OFFSET: prdata = DATA_W'(cfg.block_offset);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: tb/tb_bad_block_remap_table_unit.sv
module tb_bad_block_remap_table_unit;
  import bbrt_pkg::*;

  localparam int TABLE_ENTRIES = 128;
  localparam int ALT_LIMIT = TABLE_ENTRIES - 1;
  localparam int SEARCH_CAP = TABLE_ENTRIES / 2;
  localparam logic [BLOCK_W-1:0] BLOCK_MAX = '1;
  localparam logic [LENGTH_W-1:0] LENGTH_MAX = '1;
  localparam longint unsigned CL_BASE = 100000;
  localparam int unsigned CL_SPAN = 4000;

  typedef struct {
    op_t                 op;
    logic [BLOCK_W-1:0]  block;
    logic [LENGTH_W-1:0] length;
    bit                  typed;
    rsp_t                want;
  } step_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  req_t                req;
  logic                done;
  rsp_t                rsp;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // shadow of the block's registers and table
  logic [BLOCK_W-1:0]  lim_block;
  logic [OFFSET_W-1:0] blk_offset;
  int unsigned         bad_cnt;
  logic [BLOCK_W-1:0]  bad_tab [TABLE_ENTRIES];
  logic [7:0]          alt_tab [TABLE_ENTRIES];
  int unsigned         alt_used;

  rsp_t                pending_maps[$];
  rsp_t                want_rsp;
  step_row_t           directed_steps[$];
  int unsigned         mismatches;
  int unsigned         rnd_count;
  bit                  gaps_on;

  bad_block_remap_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit slot_used(int unsigned s);
    return s >= 1 && s <= bad_cnt && s < TABLE_ENTRIES;
  endfunction

  // power-of-two search; pos is the slot where the walk stopped
  function automatic bit find_slot(longint unsigned ob, output int unsigned pos);
    int unsigned step;
    int unsigned p;
    step = 0;
    if (bad_cnt > 0) begin
      step = 1;
      while (step * 2 <= bad_cnt && step * 2 <= SEARCH_CAP) step *= 2;
    end
    p = step;
    while (step != 0) begin
      step >>= 1;
      if (slot_used(p) && ob == bad_tab[p]) begin
        pos = p;
        return 1'b1;
      end
      if (slot_used(p) && ob > bad_tab[p]) p += step;
      else p -= step;
    end
    pos = p;
    return 1'b0;
  endfunction

  function automatic rsp_t map_request(req_t r);
    rsp_t res;
    longint unsigned ob;
    int unsigned pos;
    int unsigned x;
    int unsigned y;
    bit natural;
    res = '0;
    ob = 64'(r.block) + 64'(blk_offset);
    if (ob > lim_block) begin
      res.status = ST_BAD_ADDR;
      return res;
    end
    pos = 0;
    if (r.op == OP_TRANSLATE) begin
      if (find_slot(ob, pos)) begin
        res.mapped_block = BLOCK_W'(alt_tab[pos]);
        return res;
      end
      natural = 1'b0;
      if (slot_used(pos) && ob > bad_tab[pos]) begin
        if (pos >= ALT_LIMIT) natural = 1'b1;
        else pos++;
      end
      if (!slot_used(pos) || bad_tab[pos] >= ob + r.length) natural = 1'b1;
      res.mapped_block = ob[BLOCK_W-1:0];
      res.all_natural = natural;
      return res;
    end
    if (alt_used >= ALT_LIMIT) begin
      res.status = ST_NO_SPACE;
      return res;
    end
    if (!find_slot(ob, pos)) begin
      x = 1;
      while (x <= bad_cnt && x < ALT_LIMIT && ob > bad_tab[x]) x++;
      bad_cnt++;
      for (y = bad_cnt; y > x && y < TABLE_ENTRIES; y--) begin
        bad_tab[y] = bad_tab[y-1];
        alt_tab[y] = alt_tab[y-1];
      end
      bad_tab[x] = ob[BLOCK_W-1:0];
      pos = x;
    end
    alt_tab[pos] = 8'(alt_used + ALT_FIRST);
    alt_used++;
    res.mapped_block = BLOCK_W'(alt_tab[pos]);
    return res;
  endfunction

  function automatic rsp_t answer(logic [BLOCK_W-1:0] m, bit n, status_t s);
    rsp_t res;
    res.mapped_block = m;
    res.all_natural = n;
    res.status = s;
    return res;
  endfunction

  function automatic void add_step(op_t op, logic [BLOCK_W-1:0] blk,
                                   logic [LENGTH_W-1:0] len, bit typed, rsp_t want);
    step_row_t row;
    row.op = op;
    row.block = blk;
    row.length = len;
    row.typed = typed;
    row.want = want;
    directed_steps.push_back(row);
  endfunction

  // build a request whose offset block lands on ob where the offset allows
  function automatic req_t make_req(op_t op, longint unsigned ob, int unsigned len);
    req_t r;
    r.op = op;
    r.block = (ob >= blk_offset) ? BLOCK_W'(ob - blk_offset) : BLOCK_W'(ob);
    r.length = LENGTH_W'(len);
    return r;
  endfunction

  function automatic longint unsigned pick_entry();
    if (bad_cnt == 0) return CL_BASE + $urandom_range(0, CL_SPAN);
    return 64'(bad_tab[$urandom_range(1, bad_cnt)]);
  endfunction

  function automatic req_t make_random_req();
    req_t r;
    int unsigned pick;
    longint unsigned ob;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      if ($urandom_range(0, 3) == 0) ob = pick_entry();
      else ob = CL_BASE + $urandom_range(0, CL_SPAN);
      r = make_req(OP_REMAP, ob, $urandom_range(0, 65535));
    end else if (pick < 40) begin
      r = make_req(OP_TRANSLATE, pick_entry(), $urandom_range(0, 8));
    end else if (pick < 70) begin
      ob = pick_entry() + $urandom_range(0, 8);
      ob = (ob >= 4) ? ob - 4 : ob;
      r = make_req(OP_TRANSLATE, ob, $urandom_range(0, 16));
    end else if (pick < 82) begin
      r = make_req(OP_TRANSLATE, CL_BASE + $urandom_range(0, CL_SPAN), $urandom_range(0, 300));
    end else if (pick < 88) begin
      ob = 64'(lim_block) + $urandom_range(0, 2);
      ob = (ob > 0) ? ob - 1 : ob;
      r = make_req(op_t'($urandom_range(0, 1)), ob, $urandom_range(0, 65535));
    end else begin
      r.op = op_t'($urandom_range(0, 1));
      r.block = BLOCK_W'($urandom);
      r.length = LENGTH_W'($urandom);
    end
    return r;
  endfunction

  task automatic send_item(req_t r, bit typed, rsp_t want);
    rsp_t calc;
    if (gaps_on && $urandom_range(0, 99) < 9) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    // state must advance on typed rows as well
    calc = map_request(r);
    pending_maps.push_back(typed ? want : calc);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
  endtask

  task automatic set_register(reg_sel_t sel, logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_LAST_BLOCK) lim_block = val[BLOCK_W-1:0];
    else blk_offset = val[OFFSET_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_LAST_BLOCK) want = DATA_W'(lim_block);
    else want = DATA_W'(blk_offset);
    if (((sel == REG_LAST_BLOCK) ? DATA_W'(prdata[BLOCK_W-1:0]) :
         DATA_W'(prdata[OFFSET_W-1:0])) != want) begin
      $display("%0t: register %s read expected %0d got %0d", $time, sel.name(), want, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reconfigure(logic [BLOCK_W-1:0] last, logic [OFFSET_W-1:0] off);
    wait_drained();
    set_register(REG_LAST_BLOCK, DATA_W'(last));
    set_register(REG_BLOCK_OFFSET, DATA_W'(off));
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) begin
      // long stretch with back-to-back transfers
      gaps_on = !(rnd_count >= 600 && rnd_count < 900);
      if (rnd_count == 450 || $urandom_range(0, 199) == 0) wait_drained();
      send_item(make_random_req(), 1'b0, '0);
      rnd_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: result with none expected: mapped %0d natural %0b status %0d",
                 $time, rsp.mapped_block, rsp.all_natural, rsp.status);
        mismatches++;
      end else begin
        want_rsp = pending_maps.pop_front();
        if (rsp.mapped_block !== want_rsp.mapped_block) begin
          $display("%0t: mapped_block expected %0d got %0d", $time,
                   want_rsp.mapped_block, rsp.mapped_block);
          mismatches++;
        end
        if (rsp.all_natural !== want_rsp.all_natural) begin
          $display("%0t: all_natural expected %0b got %0b", $time,
                   want_rsp.all_natural, rsp.all_natural);
          mismatches++;
        end
        if (rsp.status !== want_rsp.status) begin
          $display("%0t: status expected %0d got %0d", $time, want_rsp.status, rsp.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    req_t r;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    lim_block = LAST_BLOCK_RESET;
    blk_offset = BLOCK_OFFSET_RESET;
    bad_cnt = 0;
    alt_used = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      bad_tab[i] = '0;
      alt_tab[i] = '0;
    end
    mismatches = 0;
    rnd_count = 0;
    gaps_on = 1'b1;

    // first row runs at reset settings, the rest with last_block max, offset 1023
    add_step(OP_TRANSLATE, 0, 0, 1'b1, answer(0, 1'b0, ST_BAD_ADDR));
    add_step(OP_TRANSLATE, 0, 0, 1'b1, answer(1023, 1'b1, ST_OK));
    add_step(OP_TRANSLATE, BLOCK_MAX, LENGTH_MAX, 1'b1, answer(0, 1'b0, ST_BAD_ADDR));
    add_step(OP_TRANSLATE, BLOCK_W'(BLOCK_MAX - 1023), LENGTH_MAX, 1'b1,
             answer(BLOCK_MAX, 1'b1, ST_OK));
    add_step(OP_REMAP, 100, 0, 1'b1, answer(7, 1'b0, ST_OK));
    add_step(OP_REMAP, 100, 0, 1'b1, answer(8, 1'b0, ST_OK));
    add_step(OP_TRANSLATE, 100, 0, 1'b1, answer(8, 1'b0, ST_OK));
    add_step(OP_REMAP, 0, LENGTH_MAX, 1'b1, answer(9, 1'b0, ST_OK));
    add_step(OP_REMAP, BLOCK_W'(BLOCK_MAX - 1023), 0, 1'b1, answer(10, 1'b0, ST_OK));
    add_step(OP_REMAP, 50, 0, 1'b1, answer(11, 1'b0, ST_OK));
    add_step(OP_TRANSLATE, 60, 0, 1'b0, '0);
    add_step(OP_TRANSLATE, 60, 40, 1'b0, '0);
    add_step(OP_TRANSLATE, 60, 41, 1'b0, '0);
    add_step(OP_TRANSLATE, BLOCK_W'(BLOCK_MAX - 1024), 0, 1'b0, '0);
    add_step(OP_TRANSLATE, BLOCK_W'(BLOCK_MAX - 1023), 0, 1'b1, answer(10, 1'b0, ST_OK));
    add_step(OP_TRANSLATE, 200, LENGTH_MAX, 1'b0, '0);
    add_step(OP_REMAP, BLOCK_MAX, 0, 1'b1, answer(0, 1'b0, ST_BAD_ADDR));
    add_step(OP_TRANSLATE, 0, 0, 1'b1, answer(9, 1'b0, ST_OK));
    add_step(OP_TRANSLATE, 1, 0, 1'b0, '0);

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (i == 1) reconfigure(BLOCK_MAX, 10'd1023);
      r.op = directed_steps[i].op;
      r.block = directed_steps[i].block;
      r.length = directed_steps[i].length;
      send_item(r, directed_steps[i].typed, directed_steps[i].want);
    end

    reconfigure(BLOCK_MAX, 10'd0);
    run_random(320);
    reconfigure(BLOCK_W'(CL_BASE + 1500), 10'd1023);
    run_random(300);
    reconfigure('0, 10'd0);
    run_random(60);
    reconfigure(BLOCK_W'($urandom_range(CL_BASE, BLOCK_MAX)), OFFSET_W'($urandom_range(0, 1023)));
    run_random(360);
    reconfigure(BLOCK_MAX, 10'd1023);
    run_random(380);
    reconfigure(BLOCK_MAX, OFFSET_W'($urandom_range(0, 1023)));
    run_random(400);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_maps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
